// File: src/tds_pkg.sv
// Package for the telemetry delta-suppression sketch.
// Hash constants, sequencer state type and a rotate helper; no dependencies.
`timescale 1ns / 1ps
package tds_pkg;
	localparam logic [31:0] C1 = 32'hcc9e2d51;
	localparam logic [31:0] C2 = 32'h1b873593;
	localparam logic [31:0] MIX_ADD = 32'he6546b64;
	localparam logic [31:0] F1 = 32'h85ebca6b;
	localparam logic [31:0] F2 = 32'hc2b2ae35;
	localparam logic [31:0] HASH_LEN = 32'd8;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_K1, ST_K2, ST_H5, ST_F1, ST_F2, ST_SLOT,
		ST_READ, ST_CMP, ST_WRITE, ST_OUT
	} state_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int r);
		rotl = (v << r) | (v >> (32 - r));
	endfunction
endpackage

// File: src/tds_if.sv
// Valid/ready channel interfaces for the sketch.
// Depends on nothing.
`timescale 1ns / 1ps
interface tds_in_if;
	logic valid;
	logic ready;
	logic [31:0] source_address;
	logic [31:0] destination_address;
	logic [15:0] carried_power;
	logic [15:0] local_power;
	modport source(output valid, source_address, destination_address, carried_power,
		local_power, input ready);
	modport sink(input valid, source_address, destination_address, carried_power,
		local_power, output ready);
endinterface

interface tds_out_if;
	logic valid;
	logic ready;
	logic [15:0] new_power;
	logic saved;
	modport source(output valid, new_power, saved, input ready);
	modport sink(input valid, new_power, saved, output ready);
endinterface

// File: src/telemetry_delta_suppression_sketch.sv
// Telemetry delta-suppression sketch: hash, table lookup and rewrite; uses tds_pkg, tds_if.sv.
// Per seed: two key rounds (K1, K2, H5) and a finalizer (F1, F2) on one shared 32x32 multiplier,
// then SLOT; then HASH_COUNT read/compare pairs and HASH_COUNT writes of the single-port table,
// then the result register is loaded in ST_OUT.
// Items are taken one at a time, only in idle; a waiting result stalls only its reload.
// Reset: arst_n clears control; a clearing pass then zeroes every table entry, ready low.
`timescale 1ns / 1ps
module telemetry_delta_suppression_sketch #(
	parameter int HASH_COUNT = 3,
	parameter int WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	tds_in_if.sink      in_ch,
	tds_out_if.source   out_ch
);
	localparam int AW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
	localparam int HW = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;
	localparam int RW = 96;

	tds_pkg::state_t state_q, state_d;

	logic [15:0] thr_q;
	logic [31:0] src_q, dst_q;
	logic [15:0] car_q, loc_q;
	logic [31:0] h_q, k_q;
	logic        second_q;
	logic [HW-1:0] seed_q;
	logic [AW-1:0] slot_q [HASH_COUNT];
	logic [AW:0]   clr_q;
	logic        found_q;
	logic [15:0] cur_in_q, prev_out_q;
	logic [15:0] pwr_q;
	logic        saved_q, oval_q;

	// table: key (64), input (16), output (16) in one word
	logic [RW-1:0] mem [WIDTH];
	logic [RW-1:0] rd_q;

	// shared multiplier
	logic [31:0] mul_a, mul_b, mul_p;
	assign mul_p = mul_a * mul_b;

	always_comb begin
		mul_a = k_q;
		mul_b = tds_pkg::C1;
		unique case (state_q)
			tds_pkg::ST_K2: begin
				mul_a = tds_pkg::rotl(k_q, 15);
				mul_b = tds_pkg::C2;
			end
			tds_pkg::ST_F1: begin
				mul_a = h_q ^ (h_q >> 16);
				mul_b = tds_pkg::F1;
			end
			tds_pkg::ST_F2: begin
				mul_a = h_q ^ (h_q >> 13);
				mul_b = tds_pkg::F2;
			end
			default: begin
			end
		endcase
	end

	logic [31:0] hfinal;
	assign hfinal = h_q ^ (h_q >> 16);

	// lookup compare on registered read data
	logic [63:0] key;
	assign key = {src_q, dst_q};
	logic hit;
	assign hit = !found_q && (rd_q[95:32] == key);

	logic [15:0] maxp, diff;
	assign maxp = (cur_in_q > loc_q) ? cur_in_q : loc_q;
	assign diff = (maxp > prev_out_q) ? maxp - prev_out_q : prev_out_q - maxp;

	logic last_seed;
	assign last_seed = (32'(seed_q) == 32'(HASH_COUNT - 1));

	// load the result register once the previous result has left or leaves now
	logic out_load;
	assign out_load = (state_q == tds_pkg::ST_OUT) && (!oval_q || out_ch.ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tds_pkg::ST_CLEAR: if (clr_q == (AW+1)'(WIDTH - 1)) state_d = tds_pkg::ST_IDLE;
			tds_pkg::ST_IDLE:  if (in_ch.valid) state_d = tds_pkg::ST_K1;
			tds_pkg::ST_K1:    state_d = tds_pkg::ST_K2;
			tds_pkg::ST_K2:    state_d = tds_pkg::ST_H5;
			tds_pkg::ST_H5:    state_d = second_q ? tds_pkg::ST_F1 : tds_pkg::ST_K1;
			tds_pkg::ST_F1:    state_d = tds_pkg::ST_F2;
			tds_pkg::ST_F2:    state_d = tds_pkg::ST_SLOT;
			tds_pkg::ST_SLOT:  state_d = last_seed ? tds_pkg::ST_READ : tds_pkg::ST_K1;
			tds_pkg::ST_READ:  state_d = tds_pkg::ST_CMP;
			tds_pkg::ST_CMP:   state_d = last_seed ? tds_pkg::ST_WRITE : tds_pkg::ST_READ;
			tds_pkg::ST_WRITE: state_d = last_seed ? tds_pkg::ST_OUT : tds_pkg::ST_WRITE;
			tds_pkg::ST_OUT:   state_d = out_load ? tds_pkg::ST_IDLE : tds_pkg::ST_OUT;
			default:           state_d = tds_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ch.ready = (state_q == tds_pkg::ST_IDLE);
	end

	assign out_ch.valid = oval_q;
	assign out_ch.new_power = pwr_q;
	assign out_ch.saved = saved_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tds_pkg::ST_CLEAR;
			thr_q <= '0;
			clr_q <= '0;
			oval_q <= 1'b0;
			seed_q <= '0;
			second_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) thr_q <= cfg_wdata;
			if (out_load) oval_q <= 1'b1;
			else if (out_ch.valid && out_ch.ready) oval_q <= 1'b0;
			unique case (state_q)
				tds_pkg::ST_CLEAR: clr_q <= clr_q + 1'b1;
				tds_pkg::ST_IDLE: begin
					seed_q <= '0;
					second_q <= 1'b0;
					found_q <= 1'b0;
				end
				tds_pkg::ST_H5: second_q <= !second_q;
				tds_pkg::ST_SLOT: if (!last_seed) seed_q <= seed_q + 1'b1;
					else seed_q <= '0;
				tds_pkg::ST_CMP: begin
					if (hit) found_q <= 1'b1;
					seed_q <= last_seed ? '0 : seed_q + 1'b1;
				end
				tds_pkg::ST_WRITE: if (!last_seed) seed_q <= seed_q + 1'b1;
				default: begin
				end
			endcase
		end
	end

	// datapath registers; no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			tds_pkg::ST_IDLE: begin
				src_q <= in_ch.source_address;
				dst_q <= in_ch.destination_address;
				car_q <= in_ch.carried_power;
				loc_q <= in_ch.local_power;
				h_q <= '0;
				k_q <= in_ch.destination_address;
			end
			tds_pkg::ST_K1: k_q <= mul_p;
			tds_pkg::ST_K2: k_q <= mul_p;
			tds_pkg::ST_H5: begin
				h_q <= tds_pkg::rotl(h_q ^ k_q, 13) * 32'd5 + tds_pkg::MIX_ADD
					^ (second_q ? tds_pkg::HASH_LEN : 32'd0);
				k_q <= src_q;
			end
			tds_pkg::ST_F1: h_q <= mul_p;
			tds_pkg::ST_F2: h_q <= mul_p;
			tds_pkg::ST_SLOT: begin
				// power-of-two width: modulo is a mask
				slot_q[seed_q] <= AW'(hfinal % 32'(WIDTH));
				h_q <= 32'(seed_q) + 32'd1;
				k_q <= dst_q;
				cur_in_q <= car_q;
				prev_out_q <= '0;
			end
			tds_pkg::ST_CMP: if (hit) begin
				if (car_q == 16'd0) cur_in_q <= rd_q[31:16];
				prev_out_q <= rd_q[15:0];
			end
			tds_pkg::ST_OUT: if (out_load) begin
				pwr_q <= (diff > thr_q) ? maxp : 16'd0;
				saved_q <= !(diff > thr_q);
			end
			default: begin
			end
		endcase
		if (state_q == tds_pkg::ST_CMP && !hit && car_q == 16'd0 && !found_q && last_seed)
			cur_in_q <= 16'd0;
	end

	// table port: clear, read, write
	logic [15:0] wr_out;
	assign wr_out = (diff > thr_q) ? maxp : prev_out_q;
	always_ff @(posedge clk) begin
		if (state_q == tds_pkg::ST_CLEAR)
			mem[clr_q[AW-1:0]] <= '0;
		else if (state_q == tds_pkg::ST_WRITE)
			mem[slot_q[seed_q]] <= {key, cur_in_q, wr_out};
		rd_q <= mem[slot_q[seed_q]];
	end

`ifndef SYNTHESIS
	a_no_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != tds_pkg::ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(oval_q && !out_ch.ready) |=> oval_q) else $error("result dropped");
	a_saved_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(oval_q && saved_q) |-> (pwr_q == 16'd0)) else $error("suppressed nonzero");
`endif
endmodule
